FILE: rtl/vlmr_pkg.sv
`timescale 1ns / 1ps
package vlmr_pkg;

  // Geometry. LINE_BYTES is a power of two, so line and word counts are shifts.
  localparam int RING_LINES = 64;
  localparam int LINE_BYTES = 64;

  localparam int WPL        = LINE_BYTES / 8;
  localparam int WPL_SHIFT  = $clog2(WPL);
  localparam int LINE_SHIFT = $clog2(LINE_BYTES);
  localparam int RING_WORDS = RING_LINES * WPL;

  localparam int DATA_W  = 64;
  localparam int LEN_W   = 13;
  localparam int STAT_W  = 3;
  localparam int LINE_W  = (RING_LINES > 1) ? $clog2(RING_LINES) : 1;
  localparam int USED_W  = $clog2(RING_LINES + 1);
  localparam int WADDR_W = $clog2(RING_WORDS);
  localparam int LEFT_W  = $clog2(RING_WORDS + 1);
  localparam int LINES_W = LEN_W - LINE_SHIFT + 1;
  localparam int CMP_W   = (LINES_W > USED_W) ? LINES_W : USED_W;

  // Result status
  localparam logic [STAT_W-1:0] ST_POPPED = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STAT_W-1:0] ST_PUSHED = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STAT_W-1:0] ST_SEQ    = 3'd4;

  // Transaction class set by the front end
  localparam logic [1:0] KIND_PUSH_START = 2'd0;
  localparam logic [1:0] KIND_PUSH_CONT  = 2'd1;
  localparam logic [1:0] KIND_POP        = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [DATA_W-1:0]  data;
    logic [LEN_W-1:0]   bytes;
    logic [LINES_W-1:0] lines;
  } vlmr_item_t;

  function automatic logic [LINES_W-1:0] lines_for(input logic [LEN_W-1:0] bytes);
    logic [LEN_W:0] sum;
    sum = {1'b0, bytes} + (LEN_W + 1)'(LINE_BYTES - 1);
    return LINES_W'(sum >> LINE_SHIFT);
  endfunction

endpackage

FILE: rtl/vlmr_front.sv
`timescale 1ns / 1ps
module vlmr_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [vlmr_pkg::DATA_W-1:0] in_word_data,
  input  logic                       in_starts_message,
  input  logic [vlmr_pkg::LEN_W-1:0] in_message_bytes,
  output logic                       q_valid,
  input  logic                       q_ready,
  output vlmr_pkg::vlmr_item_t       q_item
);
  import vlmr_pkg::*;

  vlmr_item_t  entry_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  count_r, count_nxt;
  vlmr_item_t  cls;
  logic        enq, deq;

  always_comb begin
    cls.data  = in_word_data;
    cls.bytes = in_message_bytes;
    cls.lines = lines_for(in_message_bytes);
    if (in_action) begin
      cls.kind = KIND_POP;
    end else if (in_starts_message) begin
      cls.kind = KIND_PUSH_START;
    end else begin
      cls.kind = KIND_PUSH_CONT;
    end
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = entry_r[rptr_r];
  assign enq      = in_valid && in_ready;
  assign deq      = q_valid && q_ready;

  always_comb begin
    wptr_nxt  = enq ? ~wptr_r : wptr_r;
    rptr_nxt  = deq ? ~rptr_r : rptr_r;
    count_nxt = count_r + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      entry_r[wptr_r] <= cls;
    end
  end

endmodule

FILE: rtl/vlmr_back.sv
`timescale 1ns / 1ps
module vlmr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  vlmr_pkg::vlmr_item_t        q_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vlmr_pkg::STAT_W-1:0] out_status,
  output logic [vlmr_pkg::DATA_W-1:0] out_read_data,
  output logic                        out_is_first,
  output logic                        out_is_last,
  output logic [vlmr_pkg::LEN_W-1:0]  out_popped_length
);
  import vlmr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;

  logic [DATA_W-1:0] ring_mem [RING_WORDS];
  logic [LEN_W-1:0]  len_mem  [RING_LINES];

  logic               state_r, state_nxt;
  logic [LINE_W-1:0]  head_r, head_nxt;
  logic [LINE_W-1:0]  tail_r, tail_nxt;
  logic [USED_W-1:0]  used_r, used_nxt;
  logic [WADDR_W-1:0] wcur_r, wcur_nxt;
  logic [LEFT_W-1:0]  wleft_r, wleft_nxt;
  logic [USED_W-1:0]  wlines_r, wlines_nxt;
  logic [WADDR_W-1:0] rcur_r, rcur_nxt;
  logic [LEFT_W-1:0]  rleft_r, rleft_nxt;
  logic [USED_W-1:0]  rlines_r, rlines_nxt;
  logic               rstart_r, rstart_nxt;

  logic               ovalid_r, ovalid_nxt;
  logic [STAT_W-1:0]  ostat_r, ostat_nxt;
  logic [DATA_W-1:0]  odata_r, odata_nxt;
  logic               ofirst_r, ofirst_nxt;
  logic               olast_r, olast_nxt;
  logic [LEN_W-1:0]   olen_r, olen_nxt;

  logic [DATA_W-1:0]  rd_word_q;
  logic [LEN_W-1:0]   rd_len_q;

  logic               out_free;
  logic               mem_we, len_we, rd_en;
  logic [WADDR_W-1:0] mem_waddr, rd_waddr;
  logic [WADDR_W-1:0] head_base, tail_base, wpos, rpos;
  logic [CMP_W-1:0]   need, free;
  logic [LEFT_W-1:0]  wleft_dec, rleft_dec;
  logic [USED_W-1:0]  rd_lines, end_lines;
  logic [LINE_W+1:0]  tail_sum, head_sum;

  function automatic logic [WADDR_W-1:0] next_word(input logic [WADDR_W-1:0] c);
    logic [WADDR_W:0] n;
    n = {1'b0, c} + 1'b1;
    return (n >= (WADDR_W + 1)'(RING_WORDS)) ? '0 : WADDR_W'(n);
  endfunction

  assign out_free  = !ovalid_r || out_ready;
  assign head_base = WADDR_W'(head_r) << WPL_SHIFT;
  assign tail_base = WADDR_W'(tail_r) << WPL_SHIFT;
  assign need      = CMP_W'(q_item.lines);
  assign free      = CMP_W'(USED_W'(RING_LINES) - used_r);
  assign rd_lines  = USED_W'(lines_for(rd_len_q));
  assign end_lines = rstart_r ? rd_lines : rlines_r;
  assign rpos      = rstart_r ? head_base : rcur_r;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    used_nxt   = used_r;
    wcur_nxt   = wcur_r;
    wleft_nxt  = wleft_r;
    wlines_nxt = wlines_r;
    rcur_nxt   = rcur_r;
    rleft_nxt  = rleft_r;
    rlines_nxt = rlines_r;
    rstart_nxt = rstart_r;
    ovalid_nxt = out_ready ? 1'b0 : ovalid_r;
    ostat_nxt  = ostat_r;
    odata_nxt  = odata_r;
    ofirst_nxt = ofirst_r;
    olast_nxt  = olast_r;
    olen_nxt   = olen_r;
    q_ready    = 1'b0;
    mem_we     = 1'b0;
    len_we     = 1'b0;
    mem_waddr  = wcur_r;
    rd_en      = 1'b0;
    rd_waddr   = rcur_r;
    wpos       = wcur_r;
    wleft_dec  = '0;
    rleft_dec  = '0;
    tail_sum   = '0;
    head_sum   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_ready    = 1'b1;
          ovalid_nxt = 1'b1;
          odata_nxt  = '0;
          ofirst_nxt = 1'b0;
          olast_nxt  = 1'b0;
          olen_nxt   = '0;
          unique case (q_item.kind)
            KIND_PUSH_START, KIND_PUSH_CONT: begin
              ostat_nxt = ST_PUSHED;
              if (q_item.kind == KIND_PUSH_START) begin
                wpos      = tail_base;
                wleft_dec = (LEFT_W'(q_item.lines) << WPL_SHIFT) - 1'b1;
                if (wleft_r != '0 || q_item.bytes == '0) begin
                  ostat_nxt = ST_SEQ;
                end else if (need > free) begin
                  ostat_nxt = ST_FULL;
                end else begin
                  len_we     = 1'b1;
                  wlines_nxt = USED_W'(q_item.lines);
                end
              end else begin
                wleft_dec = wleft_r - 1'b1;
                if (wleft_r == '0) begin
                  ostat_nxt = ST_SEQ;
                end
              end
              if (ostat_nxt == ST_PUSHED) begin
                mem_we    = 1'b1;
                mem_waddr = wpos;
                wcur_nxt  = next_word(wpos);
                wleft_nxt = wleft_dec;
                if (wleft_dec == '0) begin
                  tail_sum = (LINE_W + 2)'(tail_r) + (LINE_W + 2)'(wlines_nxt);
                  if (tail_sum >= (LINE_W + 2)'(RING_LINES)) begin
                    tail_sum = tail_sum - (LINE_W + 2)'(RING_LINES);
                  end
                  tail_nxt = LINE_W'(tail_sum);
                  used_nxt = used_r + wlines_nxt;
                end
              end
            end
            KIND_POP: begin
              if (rleft_r == '0 && used_r == '0) begin
                ostat_nxt = ST_EMPTY;
              end else begin
                ovalid_nxt = out_ready ? 1'b0 : ovalid_r;
                rd_en      = 1'b1;
                rd_waddr   = (rleft_r == '0) ? head_base : rcur_r;
                rstart_nxt = (rleft_r == '0);
                state_nxt  = S_RD;
              end
            end
            default: begin
              ostat_nxt = ST_SEQ;
            end
          endcase
        end
      end
      S_RD: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = ST_POPPED;
          odata_nxt  = rd_word_q;
          ofirst_nxt = rstart_r;
          olen_nxt   = rstart_r ? rd_len_q : '0;
          rleft_dec  = rstart_r ? (LEFT_W'(rd_lines) << WPL_SHIFT) - 1'b1
                                : rleft_r - 1'b1;
          rcur_nxt   = next_word(rpos);
          rleft_nxt  = rleft_dec;
          if (rstart_r) begin
            rlines_nxt = rd_lines;
          end
          olast_nxt = (rleft_dec == '0);
          if (rleft_dec == '0) begin
            head_sum = (LINE_W + 2)'(head_r) + (LINE_W + 2)'(end_lines);
            if (head_sum >= (LINE_W + 2)'(RING_LINES)) begin
              head_sum = head_sum - (LINE_W + 2)'(RING_LINES);
            end
            head_nxt = LINE_W'(head_sum);
            used_nxt = (end_lines > used_r) ? '0 : used_r - end_lines;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      used_r   <= '0;
      wcur_r   <= '0;
      wleft_r  <= '0;
      wlines_r <= '0;
      rcur_r   <= '0;
      rleft_r  <= '0;
      rlines_r <= '0;
      rstart_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      used_r   <= used_nxt;
      wcur_r   <= wcur_nxt;
      wleft_r  <= wleft_nxt;
      wlines_r <= wlines_nxt;
      rcur_r   <= rcur_nxt;
      rleft_r  <= rleft_nxt;
      rlines_r <= rlines_nxt;
      rstart_r <= rstart_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ostat_r  <= ostat_nxt;
    odata_r  <= odata_nxt;
    ofirst_r <= ofirst_nxt;
    olast_r  <= olast_nxt;
    olen_r   <= olen_nxt;
  end

  // word store: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= q_item.data;
    end
    if (rd_en) begin
      rd_word_q <= ring_mem[rd_waddr];
    end
  end

  // per-line length store, written at a message's first line
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[tail_r] <= q_item.bytes;
    end
    if (rd_en) begin
      rd_len_q <= len_mem[head_r];
    end
  end

  assign out_valid         = ovalid_r;
  assign out_status        = ostat_r;
  assign out_read_data     = odata_r;
  assign out_is_first      = ofirst_r;
  assign out_is_last       = olast_r;
  assign out_popped_length = olen_r;

endmodule

FILE: rtl/variable_length_message_ring.sv
`timescale 1ns / 1ps
// Ring store of variable-length messages padded to whole lines. A push transaction
// runs in the back end in S_IDLE alone and a pop in S_IDLE then S_RD, as the word
// and length stores read through a register; empty or rejected ones stay in S_IDLE.
// A two-entry queue after the input lets the producer run ahead of the back end.
// The back end holds while a result waits untaken and starts the next transaction
// in the cycle that result is taken.
// Every transaction returns exactly one result; store contents are undefined after
// reset, and only published messages are ever read.
module variable_length_message_ring (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [vlmr_pkg::DATA_W-1:0] in_word_data,
  input  logic                        in_starts_message,
  input  logic [vlmr_pkg::LEN_W-1:0]  in_message_bytes,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vlmr_pkg::STAT_W-1:0] out_status,
  output logic [vlmr_pkg::DATA_W-1:0] out_read_data,
  output logic                        out_is_first,
  output logic                        out_is_last,
  output logic [vlmr_pkg::LEN_W-1:0]  out_popped_length
);
  import vlmr_pkg::*;

  logic       q_valid;
  logic       q_ready;
  vlmr_item_t q_item;

  vlmr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_word_data      (in_word_data),
    .in_starts_message (in_starts_message),
    .in_message_bytes  (in_message_bytes),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_item            (q_item)
  );

  vlmr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_item            (q_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_read_data     (out_read_data),
    .out_is_first      (out_is_first),
    .out_is_last       (out_is_last),
    .out_popped_length (out_popped_length)
  );

endmodule

FILE: test/variable_length_message_ring_checker.sv
`timescale 1ns / 1ps
package ring_tb_pkg;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

endpackage

module variable_length_message_ring_checker
  import vlmr_pkg::*;
  import ring_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_action,
  input  logic [DATA_W-1:0] in_word_data,
  input  logic              in_starts_message,
  input  logic [LEN_W-1:0]  in_message_bytes,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [STAT_W-1:0] out_status,
  input  logic [DATA_W-1:0] out_read_data,
  input  logic              out_is_first,
  input  logic              out_is_last,
  input  logic [LEN_W-1:0]  out_popped_length,
  output int                error_count,
  output int                pending_count,
  output logic              push_open
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  length;
  } ring_result_t;

  logic [DATA_W-1:0]  word_store [RING_WORDS];
  logic [LEN_W-1:0]   length_store [RING_LINES];
  logic [LINE_W-1:0]  head_line;
  logic [LINE_W-1:0]  tail_line;
  logic [USED_W-1:0]  used_lines;
  logic [WADDR_W-1:0] wr_ptr;
  logic [LEFT_W-1:0]  wr_left;
  logic [WADDR_W-1:0] rd_ptr;
  logic [LEFT_W-1:0]  rd_left;

  ring_result_t awaited [$];
  int           mismatches = 0;

  function automatic int unsigned line_count(input logic [LEN_W-1:0] bytes);
    return (int'(bytes) + LINE_BYTES - 1) / LINE_BYTES;
  endfunction

  function automatic ring_result_t predict_ring(input logic act, input logic [DATA_W-1:0] data,
                                                input logic start,
                                                input logic [LEN_W-1:0] bytes);
    ring_result_t r;
    int unsigned  n;
    r = '0;
    if (act == ACT_PUSH) begin
      r.status = ST_PUSHED;
      if (start) begin
        n = line_count(bytes);
        if (wr_left != 0 || bytes == 0) begin
          r.status = ST_SEQ;
        end else if (n > RING_LINES - int'(used_lines)) begin
          r.status = ST_FULL;
        end else begin
          length_store[tail_line] = bytes;
          wr_ptr  = WADDR_W'(int'(tail_line) * WPL);
          wr_left = LEFT_W'(n * WPL);
        end
      end else if (wr_left == 0) begin
        r.status = ST_SEQ;
      end
      if (r.status == ST_PUSHED) begin
        word_store[wr_ptr] = data;
        wr_ptr  = WADDR_W'((int'(wr_ptr) + 1) % RING_WORDS);
        wr_left = wr_left - 1'b1;
        if (wr_left == 0) begin
          n = line_count(length_store[tail_line]);
          tail_line  = LINE_W'((int'(tail_line) + n) % RING_LINES);
          used_lines = USED_W'(int'(used_lines) + n);
        end
      end
    end else if (rd_left == 0 && used_lines == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_POPPED;
      if (rd_left == 0) begin
        rd_ptr   = WADDR_W'(int'(head_line) * WPL);
        rd_left  = LEFT_W'(line_count(length_store[head_line]) * WPL);
        r.first  = 1'b1;
        r.length = length_store[head_line];
      end
      r.data  = word_store[rd_ptr];
      rd_ptr  = WADDR_W'((int'(rd_ptr) + 1) % RING_WORDS);
      rd_left = rd_left - 1'b1;
      if (rd_left == 0) begin
        n = line_count(length_store[head_line]);
        head_line  = LINE_W'((int'(head_line) + n) % RING_LINES);
        used_lines = (n > used_lines) ? '0 : USED_W'(int'(used_lines) - n);
        r.last     = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    ring_result_t want;
    if (!rst_n) begin
      head_line  = '0;
      tail_line  = '0;
      used_lines = '0;
      wr_ptr     = '0;
      wr_left    = '0;
      rd_ptr     = '0;
      rd_left    = '0;
      awaited.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result transaction with nothing outstanding, status %0d", out_status);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(out_status));
          check_field("read_data", want.data, out_read_data);
          check_field("is_first", DATA_W'(want.first), DATA_W'(out_is_first));
          check_field("is_last", DATA_W'(want.last), DATA_W'(out_is_last));
          check_field("popped_length", DATA_W'(want.length), DATA_W'(out_popped_length));
        end
      end
      if (in_valid && in_ready)
        awaited.push_back(predict_ring(in_action, in_word_data, in_starts_message,
                                       in_message_bytes));
    end
    error_count   <= mismatches;
    pending_count <= awaited.size();
    push_open     <= (wr_left != 0);
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import vlmr_pkg::*;
  import ring_tb_pkg::*;

  localparam int PHASE_ITEMS    = 550;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 32;

  logic              clk               = 1'b0;
  logic              rst_n             = 1'b0;
  logic              in_valid          = 1'b0;
  logic              in_ready;
  logic              in_action         = 1'b0;
  logic [DATA_W-1:0] in_word_data      = '0;
  logic              in_starts_message = 1'b0;
  logic [LEN_W-1:0]  in_message_bytes  = '0;
  logic              out_valid;
  logic              out_ready         = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [DATA_W-1:0] out_read_data;
  logic              out_is_first;
  logic              out_is_last;
  logic [LEN_W-1:0]  out_popped_length;
  int                error_count;
  int                pending_count;
  logic              push_open;

  int src_idle_pct  = 34;
  int sink_idle_pct = 88;
  int holds_asked   = 0;
  int holds_served  = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;

  variable_length_message_ring u_top (.*);
  variable_length_message_ring_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random back-pressure, plus long hold-offs on request
  initial begin : result_sink
    int k;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        out_ready <= 1'b0;
        for (k = 0; k < LONG_HOLD; k++) @(posedge clk);
        holds_served++;
      end
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input logic act, input logic [DATA_W-1:0] data,
                           input logic start, input logic [LEN_W-1:0] bytes);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= act;
    in_word_data      <= data;
    in_starts_message <= start;
    in_message_bytes  <= bytes;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (items_sent == PHASE_ITEMS) begin
      src_idle_pct  = 88;
      sink_idle_pct = 34;
    end else if (items_sent == 2 * PHASE_ITEMS) begin
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      holds_asked++;
    end
  endtask

  task automatic pop_words(input int n);
    for (int i = 0; i < n; i++)
      send_word(ACT_POP, rand_word(), 1'($urandom_range(1)), LEN_W'($urandom_range(8191)));
  endtask

  // start word and first continuation go out together; a rejected message is dropped there
  task automatic push_message(input logic [LEN_W-1:0] bytes);
    int words;
    words = ((int'(bytes) + LINE_BYTES - 1) / LINE_BYTES) * WPL;
    send_word(ACT_PUSH, rand_word(), 1'b1, bytes);
    send_word(ACT_PUSH, rand_word(), 1'b0, LEN_W'($urandom_range(8191)));
    if (!push_open) return;
    for (int w = 2; w < words; w++) begin
      if ($urandom_range(99) < 6) pop_words(1);
      if ($urandom_range(99) < 2)
        send_word(ACT_PUSH, rand_word(), 1'b1, LEN_W'($urandom_range(1, 512)));
      send_word(ACT_PUSH, rand_word(), 1'b0, LEN_W'($urandom_range(8191)));
    end
  endtask

  initial begin : stimulus
    int pick;
    logic [LEN_W-1:0] len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(ACT_POP, '0, 1'b0, '0);
    send_word(ACT_PUSH, '1, 1'b0, LEN_W'(64));
    send_word(ACT_PUSH, '0, 1'b1, '0);
    send_word(ACT_PUSH, '0, 1'b1, LEN_W'(4097));
    send_word(ACT_PUSH, '1, 1'b1, '1);
    send_word(ACT_PUSH, '0, 1'b1, LEN_W'(1));
    send_word(ACT_PUSH, '1, 1'b0, '1);
    send_word(ACT_PUSH, rand_word(), 1'b1, LEN_W'(64));
    send_word(ACT_PUSH, {32{2'b01}}, 1'b0, '0);
    send_word(ACT_POP, '1, 1'b1, '1);
    send_word(ACT_PUSH, {32{2'b10}}, 1'b0, '0);
    send_word(ACT_PUSH, 64'd1, 1'b0, '0);
    send_word(ACT_PUSH, 64'h8000_0000_0000_0000, 1'b0, '0);
    send_word(ACT_PUSH, rand_word(), 1'b0, '1);
    send_word(ACT_PUSH, rand_word(), 1'b0, '0);
    pop_words(8);

    // whole ring in one message, wrapping; then a push against the full ring
    push_message(LEN_W'(4096));
    push_message(LEN_W'(1));

    while (items_sent < 3 * PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        pick = $urandom_range(99);
        if (pick < 85)      len = LEN_W'($urandom_range(1, 256));
        else if (pick < 95) len = LEN_W'($urandom_range(257, 1024));
        else                len = LEN_W'($urandom_range(1025, 4096));
        push_message(len);
      end else if (pick < 90) begin
        pop_words($urandom_range(1, 64));
      end else begin
        send_word(1'($urandom_range(1)), rand_word(), 1'($urandom_range(1)),
                  LEN_W'($urandom_range(8191)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/vlmr_pkg.sv
rtl/vlmr_front.sv
rtl/vlmr_back.sv
rtl/variable_length_message_ring.sv
test/variable_length_message_ring_checker.sv
test/testbench.sv
